// ===== rtl/lqi_pkg.sv =====
package lqi_pkg;

    // Operation codes carried by s_operation; codes above OP_ILV act as a status query
    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_DEQ  = 3'd1;
    localparam logic [2:0] OP_STAT = 3'd2;
    localparam logic [2:0] OP_DUMP = 3'd3;
    localparam logic [2:0] OP_ILV  = 3'd4;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_ODD   = 2'd3;

    localparam int WORD_W = 32;

endpackage

// ===== rtl/lqi_ram.sv =====
module lqi_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/linear_queue_with_interleave.sv =====
// Enqueue, status query and any rejected request: result offered in the cycle after acceptance.
// Dequeue: the front word is read from the word store (registered read), captured, then offered.
// Dump: each stored word is read, captured, then offered, one word at a time.
// Interleave of n words: copy into the scratch store, shuffle back, then a dump.
// One request at a time: s_ready is high only while the sequencer is idle.
// aresetn (synchronous, active low) empties the queue; word contents are not cleared.
module linear_queue_with_interleave
    import lqi_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [WORD_W-1:0] m_data_word,
    output logic                     m_is_empty,
    output logic                     m_is_full,
    output logic                     m_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEQ_CAP,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_CAP,
        S_COPY_RD,
        S_COPY_WR,
        S_SHUF_RD,
        S_SHUF_WR
    } state_t;

    state_t                     state_reg;
    logic [IW-1:0]              front_reg;
    logic [IW-1:0]              rear_reg;
    logic                       occ_reg;
    logic [IW-1:0]              cnt_reg;
    status_t                    status_reg;
    logic signed [WORD_W-1:0]   data_reg;
    logic                       last_reg;

    logic                       s_fire;
    logic                       m_fire;
    logic [IW-1:0]              idx_sum;
    logic [IW-1:0]              span;
    logic [IW-1:0]              half;
    logic                       enq_ok;

    logic                       st_we;
    logic [IW-1:0]              st_waddr;
    logic [WORD_W-1:0]          st_wdata;
    logic [IW-1:0]              st_raddr;
    logic [WORD_W-1:0]          st_rdata;
    logic                       tm_we;
    logic [IW-1:0]              tm_raddr;
    logic [WORD_W-1:0]          tm_rdata;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // Shared address adder: every walk of the word store runs from the front slot
    assign idx_sum = front_reg + cnt_reg;
    assign span    = rear_reg - front_reg;
    assign half    = (span >> 1) + IW'(1);
    assign enq_ok  = !occ_reg || (rear_reg != LAST_IDX);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = idx_sum;
        st_wdata = tm_rdata;
        if (state_reg == S_SHUF_WR) begin
            st_we = 1'b1;
        end else if (s_fire && (s_operation == OP_ENQ) && enq_ok) begin
            st_we    = 1'b1;
            st_waddr = occ_reg ? (rear_reg + IW'(1)) : '0;
            st_wdata = s_value;
        end
    end

    assign st_raddr = (state_reg == S_IDLE) ? front_reg : idx_sum;
    assign tm_we    = (state_reg == S_COPY_WR);
    // Even positions take the first half, odd positions the second
    assign tm_raddr = cnt_reg[0] ? (half + (cnt_reg >> 1)) : (cnt_reg >> 1);

    lqi_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    lqi_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_scratch (
        .aclk    (aclk),
        .wr_en   (tm_we),
        .wr_addr (cnt_reg),
        .wr_data (st_rdata),
        .rd_addr (tm_raddr),
        .rd_data (tm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        status_reg <= ST_OK;
                        data_reg   <= '0;
                        last_reg   <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= S_RESP;
                        unique case (s_operation)
                            OP_ENQ: begin
                                if (!occ_reg) begin
                                    front_reg <= '0;
                                    rear_reg  <= '0;
                                    occ_reg   <= 1'b1;
                                end else if (rear_reg == LAST_IDX) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    rear_reg <= rear_reg + IW'(1);
                                end
                            end
                            OP_DEQ: begin
                                if (!occ_reg) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    if (front_reg == rear_reg) begin
                                        front_reg <= '0;
                                        rear_reg  <= '0;
                                        occ_reg   <= 1'b0;
                                    end else begin
                                        front_reg <= front_reg + IW'(1);
                                    end
                                    state_reg <= S_DEQ_CAP;
                                end
                            end
                            OP_DUMP: begin
                                if (!occ_reg) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    state_reg <= S_DUMP_RD;
                                end
                            end
                            OP_ILV: begin
                                if (!occ_reg) begin
                                    status_reg <= ST_EMPTY;
                                end else if (!span[0]) begin
                                    // even span means an odd word count
                                    status_reg <= ST_ODD;
                                end else begin
                                    state_reg <= S_COPY_RD;
                                end
                            end
                            default: begin
                                status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_DEQ_CAP: begin
                    data_reg  <= $signed(st_rdata);
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (m_fire) begin
                        if (last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + IW'(1);
                            state_reg <= S_DUMP_RD;
                        end
                    end
                end
                S_DUMP_RD: begin
                    state_reg <= S_DUMP_CAP;
                end
                S_DUMP_CAP: begin
                    status_reg <= ST_OK;
                    data_reg   <= $signed(st_rdata);
                    last_reg   <= (idx_sum == rear_reg);
                    state_reg  <= S_RESP;
                end
                S_COPY_RD: begin
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (cnt_reg == span) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SHUF_RD;
                    end else begin
                        cnt_reg   <= cnt_reg + IW'(1);
                        state_reg <= S_COPY_RD;
                    end
                end
                S_SHUF_RD: begin
                    state_reg <= S_SHUF_WR;
                end
                S_SHUF_WR: begin
                    if (cnt_reg == span) begin
                        cnt_reg   <= '0;
                        state_reg <= S_DUMP_RD;
                    end else begin
                        cnt_reg   <= cnt_reg + IW'(1);
                        state_reg <= S_SHUF_RD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_status    = status_reg;
    assign m_data_word = data_reg;
    assign m_is_empty  = !occ_reg;
    assign m_is_full   = occ_reg && (rear_reg == LAST_IDX);
    assign m_last      = last_reg;

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request accepted while a result is pending");

    a_empty_indices: assert property (@(posedge aclk) disable iff (!aresetn)
        !occ_reg |-> (front_reg == '0) && (rear_reg == '0))
        else $error("empty queue with nonzero indices");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg |-> (front_reg <= rear_reg))
        else $error("front index passed rear index");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> m_last)
        else $error("rejected request not marked last");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP_CAP) |-> (cnt_reg <= span))
        else $error("dump walked past the rear index");

endmodule
